### hdl/wrsi_pkg.sv
// Shared constants for the Wilder RSI stream core.
// Used by the core and the port checker; depends on nothing.
`default_nettype none

package wrsi_pkg;

	localparam int ACC_BITS = 61;
	localparam int PERIOD_W = 10;
	localparam int RSI_W    = 15;
	localparam int MUL_W    = 15;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd14;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 10'd2;
	localparam logic [RSI_W-1:0]    RSI_FULL     = 15'd25600;

endpackage

`default_nettype wire

### hdl/wrsi_div.sv
// Shared restoring divider, one quotient bit per cycle, dividend left-aligned.
// Used by wilder_rsi_stream_core; no package dependencies.
`default_nettype none

module wrsi_div #(
	parameter int DVD_W = 77,
	parameter int DVS_W = 62,
	parameter int QUO_W = 61,
	parameter int LEN_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [LEN_W-1:0] len,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic [QUO_W-1:0]      quotient
);

	logic             busy_q;
	logic [LEN_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= len != '0;
			cnt_q  <= len;
		end else if (busy_q) begin
			busy_q <= cnt_q != LEN_W'(1);
			cnt_q  <= cnt_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### hdl/wilder_rsi_stream_core.sv
// Wilder RSI stream core: top level with sequencer, accumulators and output register.
// Depends on wrsi_pkg and wrsi_div.
//
// One price per input item, one result item per input item. From the change that ends
// warm-up on, every item runs three divisions one after another on a single shared
// bit-serial divider (one quotient bit per cycle). The ratio division is skipped when
// either average is zero. Input ready is high only while the sequencer is idle; a
// finished result sits in the output register, so the next price is taken while that
// result waits. rsi_value is in units of 1/256 and rsi_valid (tuser) is set once
// period changes have been averaged.
`default_nettype none

module wilder_rsi_stream_core #(
	parameter int PRICE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [9:0]  cfg_wdata,     // period
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] price
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [14:0] rsi_value, [15] zero
	output logic [0:0]       m_axis_tuser   // [0] rsi_valid
);

	localparam int AW    = wrsi_pkg::ACC_BITS;
	localparam int PW_I  = wrsi_pkg::PERIOD_W;
	localparam int RW    = wrsi_pkg::RSI_W;
	localparam int MW    = wrsi_pkg::MUL_W;
	localparam int PW    = (PRICE_BITS < 32) ? PRICE_BITS : 32;
	localparam int EXT_W = (FRAC_BITS > MW) ? FRAC_BITS : MW;
	localparam int DVD_W = AW + EXT_W;
	localparam int DVS_W = AW + 1;
	localparam int LEN_W = $clog2(DVD_W + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ACCUM  = 4'd1;
	localparam logic [3:0] ST_G_GO   = 4'd2;
	localparam logic [3:0] ST_G_WAIT = 4'd3;
	localparam logic [3:0] ST_L_GO   = 4'd4;
	localparam logic [3:0] ST_L_WAIT = 4'd5;
	localparam logic [3:0] ST_R_GO   = 4'd6;
	localparam logic [3:0] ST_R_WAIT = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]      state_q;
	logic [PW_I-1:0] period_q;
	logic [PW_I-1:0] p_eff;
	logic [PW-1:0]   prev_q;
	logic            have_prev_q;
	logic [PW_I-1:0] cnt_q;
	logic [PW_I-1:0] cnt_nxt;
	logic [AW-1:0]   g_acc_q;
	logic [AW-1:0]   l_acc_q;
	logic [PW-1:0]   gain_q;
	logic [PW-1:0]   loss_q;
	logic            seed_q;
	logic            up_q;
	logic [RW-1:0]   res_value_q;
	logic            res_valid_q;
	logic            out_valid_q;
	logic [RW-1:0]   out_value_q;
	logic            out_flag_q;

	logic [PW-1:0]   price_in;
	logic            accept;
	logic            out_load;
	logic            rise;
	logic            sel_gain;
	logic [AW-1:0]   acc_sel;
	logic [AW-1:0]   x_sel;
	logic            up_w;
	logic [AW-1:0]   mag;
	logic [AW-1:0]   new_acc;
	logic [DVD_W-1:0] g_ext;
	logic [DVD_W-1:0] prod;
	logic [DVS_W-1:0] sum_gl;
	logic             nz_both;

	logic             div_start;
	logic [LEN_W-1:0] div_len;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_busy;
	logic [AW-1:0]    div_quo;

	assign p_eff    = (period_q < wrsi_pkg::PERIOD_MIN) ? wrsi_pkg::PERIOD_MIN : period_q;
	assign price_in = s_axis_tdata[PW-1:0];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign rise     = price_in > prev_q;
	assign cnt_nxt  = cnt_q + PW_I'(1);

	assign sel_gain = (state_q == ST_G_GO) || (state_q == ST_G_WAIT);
	assign acc_sel  = sel_gain ? g_acc_q : l_acc_q;
	assign x_sel    = sel_gain ? {{(AW-PW-FRAC_BITS){1'b0}}, gain_q, {FRAC_BITS{1'b0}}}
	                           : {{(AW-PW-FRAC_BITS){1'b0}}, loss_q, {FRAC_BITS{1'b0}}};
	assign up_w     = x_sel >= acc_sel;
	assign mag      = up_w ? (x_sel - acc_sel) : (acc_sel - x_sel);
	assign new_acc  = seed_q ? div_quo : (up_q ? (acc_sel + div_quo) : (acc_sel - div_quo));

	// 25600 = 2^14 + 2^13 + 2^10
	assign g_ext   = DVD_W'(g_acc_q);
	assign prod    = ((g_ext << 14) + (g_ext << 13) + (g_ext << 10)) << (EXT_W - MW);
	assign sum_gl  = {1'b0, g_acc_q} + {1'b0, l_acc_q};
	assign nz_both = (l_acc_q != '0) && (g_acc_q != '0);

	always_comb begin
		div_start = 1'b0;
		div_len   = '0;
		div_dvd   = {mag, {EXT_W{1'b0}}};
		div_dvs   = DVS_W'(p_eff);
		case (state_q)
			ST_G_GO, ST_L_GO: begin
				div_start = 1'b1;
				if (seed_q) begin
					div_len = LEN_W'(AW + FRAC_BITS);
					div_dvd = {acc_sel, {EXT_W{1'b0}}};
				end else begin
					div_len = LEN_W'(AW);
				end
			end
			ST_R_GO: begin
				div_start = nz_both;
				div_len   = LEN_W'(AW + MW);
				div_dvd   = prod;
				div_dvs   = sum_gl;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	wrsi_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W),
		.QUO_W(AW),
		.LEN_W(LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.len      (div_len),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= wrsi_pkg::PERIOD_RESET;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			g_acc_q     <= '0;
			l_acc_q     <= '0;
			seed_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				period_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q      <= price_in;
						have_prev_q <= 1'b1;
						if (!have_prev_q) begin
							state_q <= ST_DONE;
						end else if (cnt_q < p_eff) begin
							state_q <= ST_ACCUM;
						end else begin
							cnt_q   <= p_eff;
							seed_q  <= 1'b0;
							state_q <= ST_G_GO;
						end
					end
				end
				ST_ACCUM: begin
					g_acc_q <= g_acc_q + AW'(gain_q);
					l_acc_q <= l_acc_q + AW'(loss_q);
					cnt_q   <= cnt_nxt;
					if (cnt_nxt >= p_eff) begin
						seed_q  <= 1'b1;
						state_q <= ST_G_GO;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_G_GO: begin
					state_q <= ST_G_WAIT;
				end
				ST_G_WAIT: begin
					if (!div_busy) begin
						g_acc_q <= new_acc;
						state_q <= ST_L_GO;
					end
				end
				ST_L_GO: begin
					state_q <= ST_L_WAIT;
				end
				ST_L_WAIT: begin
					if (!div_busy) begin
						l_acc_q <= new_acc;
						state_q <= ST_R_GO;
					end
				end
				ST_R_GO: begin
					state_q <= nz_both ? ST_R_WAIT : ST_DONE;
				end
				ST_R_WAIT: begin
					if (!div_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					gain_q      <= rise ? (price_in - prev_q) : '0;
					loss_q      <= rise ? '0 : (prev_q - price_in);
					res_value_q <= '0;
					res_valid_q <= 1'b0;
				end
			end
			ST_G_GO, ST_L_GO: begin
				up_q <= up_w;
			end
			ST_R_GO: begin
				res_valid_q <= 1'b1;
				if (l_acc_q == '0) begin
					res_value_q <= wrsi_pkg::RSI_FULL;
				end else begin
					res_value_q <= '0;
				end
			end
			ST_R_WAIT: begin
				if (!div_busy) begin
					res_value_q <= div_quo[RW-1:0];
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_value_q <= res_value_q;
					out_flag_q  <= res_valid_q;
				end
			end
			default: begin
				up_q <= up_q;
			end
		endcase
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_value_q};
	assign m_axis_tuser  = out_flag_q;

endmodule

`default_nettype wire

### hdl/wrsi_chk.sv
// Port-level checker for wilder_rsi_stream_core, with its bind statement.
// Depends on wrsi_pkg.
`default_nettype none

module wrsi_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:0] <= wrsi_pkg::RSI_FULL)
		else $error("rsi_value above full scale");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
		else $error("invalid item carries a nonzero value");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while an item is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output item changed");

endmodule

bind wilder_rsi_stream_core wrsi_chk u_wrsi_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
